// ----- src/bcdcs_pkg.sv -----
// Shared constants, codes and helpers for the packed BCD convert and subtract core.
package bcdcs_pkg;

  // Number of register stages from the input beat to the result strobe.
  localparam int PIPE_DEPTH = 11;

  // Command codes on the cmd port.
  localparam logic [1:0] CMD_BCD2BIN = 2'd0;
  localparam logic [1:0] CMD_BIN2BCD = 2'd1;
  localparam logic [1:0] CMD_SUB     = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] TOP_WEIGHT = 32'd10_000_000;

  // Reciprocals for division by constants.
  // RECIP_TOP:  floor(2^32 / 78125), estimate of (v >> 7) / 78125, low by at most one.
  // RECIP_1000: ceil(2^38 / 1000), exact for 32-bit dividends.
  // RECIP_100:  ceil(2^19 / 100), exact below 43699.
  // RECIP_10:   ceil(2^11 / 10), exact below 1029.
  localparam logic [15:0] RECIP_TOP  = 16'd54975;
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam logic [7:0]  RECIP_10   = 8'd205;

  // What the output stage drives onto the result port.
  typedef enum logic [1:0] {
    KIND_BIN   = 2'd0,
    KIND_BCD   = 2'd1,
    KIND_UNDER = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_t;

  // Two packed nibbles weighted as tens and ones; nibbles above 9 count at face value.
  function automatic logic [7:0] pair_value(input logic [7:0] nibs);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, nibs[7:4]};
    lo = {4'd0, nibs[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// ----- src/bcd32_convert_and_subtract_core.sv -----
// Pipelined 8-digit packed BCD to binary, binary to BCD and BCD subtract core.
// A beat taken at a rising edge shows its result with done high once it has
// passed through every pipeline stage; done lasts exactly one cycle per beat.
// Throughput: one beat per cycle; busy is always low since nothing in the
// pipeline waits, and the receiver cannot stall the result.
// Reset (rst, synchronous, active high) clears every stage valid bit and done;
// beats in flight are dropped, and the data registers keep stale values.
module bcd32_convert_and_subtract_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [31:0] result,
  output logic        underflow
);
  import bcdcs_pkg::*;

  // Stage map:
  //   1  fold digit pairs of both operands into values below 166
  //   2  weight the four pairs into 32-bit binary values
  //   3  pick the value to convert, compare and subtract for cmd 2
  //   4  estimate v / 10^7 by a reciprocal multiply
  //   5  correct the estimate; top nibble and a 7-digit remainder
  //   6  split the remainder by 1000 (high four digits)
  //   7  low three digits; high four digits split by 100
  //   8  further splits by 100 and 10
  //   9  digits 6, 5 and 2
  //   10 digits 4 and 3
  //   11 digits 1 and 0, result selection (output registers)

  logic accept;
  logic [PIPE_DEPTH-1:1] vld;

  // Stage 1 registers and logic.
  logic [1:0]  cmd1;
  logic [31:0] a_raw1;
  logic [7:0]  pa1 [4];
  logic [7:0]  pb1 [4];
  logic [7:0]  pa_next [4];
  logic [7:0]  pb_next [4];

  // Stage 2.
  logic [1:0]  cmd2;
  logic [31:0] a_raw2;
  logic [31:0] ba2;
  logic [31:0] bb2;
  logic [31:0] ba_next;
  logic [31:0] bb_next;

  // Item kind and binary value travel with the beat from stage 3 onward.
  kind_t       kind_q [3:PIPE_DEPTH-1];
  logic [31:0] v_q    [3:PIPE_DEPTH-1];
  kind_t       kind3_next;
  logic [31:0] v3_next;

  // Stage 4.
  logic [8:0]  q4;
  logic [40:0] prod4;

  // Stage 5; the BCD word fills in nibble by nibble from here on.
  logic [31:0] bcd_q [5:PIPE_DEPTH-1];
  logic [23:0] rest5;
  logic [31:0] r5;
  logic [31:0] r5_adj;
  logic [8:0]  q5_adj;
  logic        r5_over;

  // Stage 6.
  logic [13:0] h6;
  logic [23:0] rest6;
  logic [52:0] prod6;

  // Stage 7.
  logic [13:0] h7;
  logic [9:0]  l7;
  logic [6:0]  hh7;
  logic [23:0] l7_wide;
  logic [26:0] prod7;

  // Stage 8.
  logic [6:0]  hh8;
  logic [6:0]  hl8;
  logic [9:0]  l8;
  logic [3:0]  lh8;
  logic [3:0]  hht8;
  logic [13:0] hl8_wide;
  logic [22:0] prod8a;
  logic [14:0] prod8b;

  // Stage 9.
  logic [6:0]  ll9;
  logic [6:0]  hl9;
  logic [3:0]  hlt9;
  logic [9:0]  ll9_wide;
  logic [6:0]  d5_wide;
  logic [14:0] prod9;

  // Stage 10.
  logic [6:0]  ll10;
  logic [3:0]  llt10;
  logic [6:0]  d3_wide;
  logic [14:0] prod10;

  // Output stage.
  logic [6:0]  d0_wide;
  logic [31:0] result_next;

  // Nothing in the pipeline ever holds a beat back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: pairs of digits.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pa_next[k] = pair_value(operand_a[8*k +: 8]);
      pb_next[k] = pair_value(operand_b[8*k +: 8]);
    end
  end

  // Stage 2: weight the pairs by powers of one hundred.
  always_comb begin
    ba_next = 32'(pa1[3]) * 32'd1_000_000 + 32'(pa1[2]) * 32'd10_000
            + 32'(pa1[1]) * 32'd100 + 32'(pa1[0]);
    bb_next = 32'(pb1[3]) * 32'd1_000_000 + 32'(pb1[2]) * 32'd10_000
            + 32'(pb1[1]) * 32'd100 + 32'(pb1[0]);
  end

  // Stage 3: the command decides what reaches the conversion and the output.
  always_comb begin
    kind3_next = KIND_ZERO;
    v3_next    = ba2;
    unique case (cmd2)
      CMD_BCD2BIN: begin
        kind3_next = KIND_BIN;
        v3_next    = ba2;
      end
      CMD_BIN2BCD: begin
        kind3_next = KIND_BCD;
        v3_next    = a_raw2;
      end
      CMD_SUB: begin
        if (ba2 < bb2) begin
          kind3_next = KIND_UNDER;
        end else begin
          kind3_next = KIND_BCD;
        end
        v3_next = ba2 - bb2;
      end
      CMD_NONE: begin
        kind3_next = KIND_ZERO;
        v3_next    = ba2;
      end
    endcase
  end

  // Stage 4: 10^7 = 2^7 * 78125, so the estimate works on v >> 7.
  assign prod4 = 41'(v_q[3][31:7]) * 41'(RECIP_TOP);

  // Stage 5: the estimate is at most one low; one compare and subtract fixes it.
  always_comb begin
    r5      = v_q[4] - 32'(q4) * TOP_WEIGHT;
    r5_over = (r5 >= TOP_WEIGHT);
    r5_adj  = r5_over ? (r5 - TOP_WEIGHT) : r5;
    q5_adj  = r5_over ? (q4 + 9'd1) : q4;
  end

  // Stage 6: remainder split by one thousand.
  assign prod6 = 53'(rest5) * 53'(RECIP_1000);

  // Stage 7.
  assign l7_wide = rest6 - 24'(h6) * 24'd1000;
  assign prod7   = 27'(h6) * 27'(RECIP_100);

  // Stage 8.
  assign hl8_wide = h7 - 14'(hh7) * 14'd100;
  assign prod8a   = 23'(l7) * 23'(RECIP_100);
  assign prod8b   = 15'(hh7) * 15'(RECIP_10);

  // Stage 9.
  assign ll9_wide = l8 - 10'(lh8) * 10'd100;
  assign d5_wide  = hh8 - 7'(hht8) * 7'd10;
  assign prod9    = 15'(hl8) * 15'(RECIP_10);

  // Stage 10.
  assign d3_wide = hl9 - 7'(hlt9) * 7'd10;
  assign prod10  = 15'(ll9) * 15'(RECIP_10);

  // Output stage.
  assign d0_wide = ll10 - 7'(llt10) * 7'd10;

  always_comb begin
    result_next = '0;
    unique case (kind_q[PIPE_DEPTH-1])
      KIND_BIN:   result_next = v_q[PIPE_DEPTH-1];
      KIND_BCD:   result_next = {bcd_q[PIPE_DEPTH-1][31:8], llt10, d0_wide[3:0]};
      KIND_UNDER: result_next = ALL_ONES;
      KIND_ZERO:  result_next = '0;
    endcase
  end

  // Control: valid bits and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[PIPE_DEPTH-2:1], accept};
      done <= vld[PIPE_DEPTH-1];
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    cmd1   <= cmd;
    a_raw1 <= operand_a;
    pa1    <= pa_next;
    pb1    <= pb_next;

    cmd2   <= cmd1;
    a_raw2 <= a_raw1;
    ba2    <= ba_next;
    bb2    <= bb_next;

    kind_q[3] <= kind3_next;
    v_q[3]    <= v3_next;
    for (int i = 4; i < PIPE_DEPTH; i++) begin
      kind_q[i] <= kind_q[i-1];
      v_q[i]    <= v_q[i-1];
    end

    q4 <= prod4[40:32];

    bcd_q[5] <= {q5_adj[3:0], 28'd0};
    rest5    <= r5_adj[23:0];

    bcd_q[6] <= bcd_q[5];
    h6       <= prod6[51:38];
    rest6    <= rest5;

    bcd_q[7] <= bcd_q[6];
    h7       <= h6;
    l7       <= l7_wide[9:0];
    hh7      <= prod7[25:19];

    bcd_q[8] <= bcd_q[7];
    hh8      <= hh7;
    hl8      <= hl8_wide[6:0];
    l8       <= l7;
    lh8      <= prod8a[22:19];
    hht8     <= prod8b[14:11];

    bcd_q[9] <= {bcd_q[8][31:28], hht8, d5_wide[3:0], 8'd0, lh8, 8'd0};
    ll9      <= ll9_wide[6:0];
    hl9      <= hl8;
    hlt9     <= prod9[14:11];

    bcd_q[10] <= {bcd_q[9][31:20], hlt9, d3_wide[3:0], bcd_q[9][11:0]};
    ll10      <= ll9;
    llt10     <= prod10[14:11];

    result    <= result_next;
    underflow <= (kind_q[PIPE_DEPTH-1] == KIND_UNDER);
  end

  // Every accepted beat produces its strobe once it has passed through every stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_DEPTH) done)
    else $error("result strobe missing for an accepted beat");

  // The corrected quotient leaves a remainder below ten million.
  a_top_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (rest5 < TOP_WEIGHT[23:0]))
    else $error("top digit correction left remainder out of range");

  // The low three digits stay below one thousand.
  a_low_digits: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (l7 < 10'd1000))
    else $error("thousands split produced an out of range remainder");

  // An underflow flag seen together with a strobe comes with an all-ones result.
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    underflow && done |-> (result == ALL_ONES))
    else $error("underflow without all-ones result");

  // A strobe only follows a valid beat in the last stage.
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[PIPE_DEPTH-1]))
    else $error("result strobe without a valid beat behind it");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the packed BCD convert and subtract core.
module testbench;
  import bcdcs_pkg::*;

  // Cycles without any beat taken or result seen before the run is declared hung.
  // The slowest correct stretch is a full pipeline drain plus the longest idle
  // burst the sender draws, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;

  // One predicted result beat, with the command kept for the mismatch line.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        underflow;
  } bcd_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = CMD_NONE;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        done;
  logic [31:0] result;
  logic        underflow;

  // Predicted results in the order their input beats were taken.
  bcd_outcome_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  // When set, the sender inserts random idle bursts between beats.
  bit           gaps_on = 1'b1;

  bcd32_convert_and_subtract_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .result    (result),
    .underflow (underflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Packed BCD to binary. Every nibble is weighted by its power of ten at face
  // value, so A..F count as 10..15; the worst case still fits in 32 bits.
  function automatic logic [31:0] packed_bcd_value(input logic [31:0] digits);
    logic [31:0] acc;
    logic [31:0] weight;
    acc = '0;
    weight = 32'd1;
    for (int k = 0; k < 8; k++) begin
      acc = acc + {28'd0, digits[4*k +: 4]} * weight;
      weight = weight * 32'd10;
    end
    return acc;
  endfunction

  // Binary to packed BCD. The low seven nibbles are ordinary decimal digits;
  // the top nibble is the count of ten millions, wrapped modulo 16.
  function automatic logic [31:0] binary_to_packed_bcd(input logic [31:0] value);
    logic [31:0] digits;
    logic [31:0] upper;
    logic [31:0] rest;
    upper = value / TOP_WEIGHT;
    rest = value % TOP_WEIGHT;
    digits = '0;
    digits[31:28] = upper[3:0];
    for (int k = 0; k < 7; k++) begin
      digits[4*k +: 4] = 4'(rest % 32'd10);
      rest = rest / 32'd10;
    end
    return digits;
  endfunction

  function automatic bcd_outcome_t predict_bcd_unit(input logic [1:0] op,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b);
    bcd_outcome_t outcome;
    logic [31:0]  minuend;
    logic [31:0]  subtrahend;
    outcome.op = op;
    outcome.value = '0;
    outcome.underflow = 1'b0;
    case (op)
      CMD_BCD2BIN: begin
        outcome.value = packed_bcd_value(a);
      end
      CMD_BIN2BCD: begin
        outcome.value = binary_to_packed_bcd(a);
      end
      CMD_SUB: begin
        minuend = packed_bcd_value(a);
        subtrahend = packed_bcd_value(b);
        if (minuend < subtrahend) begin
          outcome.value = ALL_ONES;
          outcome.underflow = 1'b1;
        end else begin
          outcome.value = binary_to_packed_bcd(minuend - subtrahend);
        end
      end
      default: begin
        // The unused command returns zero with no underflow.
      end
    endcase
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, seen, wanted);
    error_count++;
  endtask

  // Everything is sampled at the rising edge, where the values seen are those
  // that held during the cycle just ending. The result side is checked before
  // the new beat is queued, so a strobe can never be matched against the beat
  // taken at the same edge.
  always @(posedge clk) begin
    bcd_outcome_t oldest;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result strobe with nothing pending", result, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (result !== oldest.value) begin
            report_mismatch($sformatf("result (cmd %0d)", oldest.op), result, oldest.value);
          end
          if (underflow !== oldest.underflow) begin
            report_mismatch($sformatf("underflow (cmd %0d)", oldest.op),
                            {31'd0, underflow}, {31'd0, oldest.underflow});
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_bcd_unit(cmd, operand_a, operand_b));
      end
    end
  end

  // The watchdog restarts on every beat taken and every result strobe.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drives one command beat and returns at the edge where it was taken, with
  // start still high so the next beat can follow without a gap. An idle burst,
  // when one is drawn, lowers start first.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has arrived. The
  // first edge lets the checker queue the beat that was taken last.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Valid packed BCD with one to eight low digits drawn and the rest zero.
  function automatic logic [31:0] random_packed_bcd();
    logic [31:0] digits;
    int unsigned count;
    digits = '0;
    count = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) begin
      if (k < count) digits[4*k +: 4] = 4'($urandom_range(0, 9));
    end
    return digits;
  endfunction

  // BCD input for the conversion and subtract commands: mostly well formed,
  // the rest raw random words, which may carry non-decimal nibbles.
  function automatic logic [31:0] random_bcd_operand();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return random_packed_bcd();
  endfunction

  // Binary input for the BCD encoder, spread over the full word, the
  // eight-digit range and the point where the top nibble wraps.
  function automatic logic [31:0] random_binary_operand();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 99_999_999);
      2: return 32'd160_000_000 + $urandom_range(0, 64) - 32'd32;
      3: return $urandom_range(0, 9_999);
      default: return $urandom_range(99_999_990, 170_000_000);
    endcase
  endfunction

  task automatic send_random_beat();
    logic [31:0] a;
    logic [31:0] b;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 5) begin
      send_beat(CMD_BCD2BIN, random_bcd_operand(), $urandom);
    end else if (pick < 10) begin
      send_beat(CMD_BIN2BCD, random_binary_operand(), $urandom);
    end else if (pick < 15) begin
      a = random_bcd_operand();
      // Some subtracts use equal operands so the zero difference recurs.
      b = ($urandom_range(0, 7) == 0) ? a : random_bcd_operand();
      send_beat(CMD_SUB, a, b);
    end else begin
      send_beat(CMD_NONE, $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Decode of the extremes, including nibbles A..F weighted at face value.
  task automatic test_bcd_to_binary();
    send_beat(CMD_BCD2BIN, 32'h0000_0000, 32'h0);
    send_beat(CMD_BCD2BIN, 32'h9999_9999, 32'h0);
    send_beat(CMD_BCD2BIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_BCD2BIN, 32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(CMD_BCD2BIN, 32'h1234_5678, 32'h0);
    send_beat(CMD_BCD2BIN, 32'hF000_0000, 32'h0);
  endtask

  // Encode around eight digits, where the top nibble grows past 9 and wraps.
  task automatic test_binary_to_bcd();
    send_beat(CMD_BIN2BCD, 32'd0, 32'h0);
    send_beat(CMD_BIN2BCD, 32'd9_999_999, 32'h0);
    send_beat(CMD_BIN2BCD, 32'd99_999_999, 32'h0);
    send_beat(CMD_BIN2BCD, 32'd100_000_000, 32'h0);
    send_beat(CMD_BIN2BCD, 32'd159_999_999, 32'h0);
    send_beat(CMD_BIN2BCD, 32'd160_000_000, 32'h0);
    send_beat(CMD_BIN2BCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Subtract: equal operands, underflow by one, the widest difference and
  // non-decimal nibbles on both sides.
  task automatic test_subtract();
    send_beat(CMD_SUB, 32'h0000_0000, 32'h0000_0000);
    send_beat(CMD_SUB, 32'h1234_5678, 32'h1234_5678);
    send_beat(CMD_SUB, 32'h0000_0000, 32'h0000_0001);
    send_beat(CMD_SUB, 32'h9999_9999, 32'h0000_0000);
    send_beat(CMD_SUB, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(CMD_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_SUB, 32'h0000_000A, 32'h0000_0010);
    send_beat(CMD_SUB, 32'h0000_0009, 32'h0000_0010);
  endtask

  // The unused command must return zero without underflow whatever the operands.
  task automatic test_unused_command();
    send_beat(CMD_NONE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(CMD_NONE, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Random traffic with idle bursts; halfway the sender stops until the
  // pipeline has fully drained, then picks up again.
  task automatic test_random_traffic(input int unsigned beats);
    for (int unsigned n = 0; n < beats; n++) begin
      if (n == beats / 2) wait_for_drain();
      send_random_beat();
    end
  endtask

  // Back-to-back beats with no idling, one per cycle.
  task automatic test_full_rate(input int unsigned beats);
    gaps_on = 1'b0;
    for (int unsigned n = 0; n < beats; n++) send_random_beat();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bcd_to_binary();
    test_binary_to_bcd();
    test_subtract();
    test_unused_command();
    wait_for_drain();
    test_random_traffic(560);
    test_full_rate(70);

    wait_for_drain();
    // Spare cycles after the drain catch any stray strobe after the last result.
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
